/* hw/rtl/free_run_histogram_scanner_unit_defines.svh */
// ---------------------------------------------------------------------------
// Free run histogram scanner: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef FREE_RUN_HISTOGRAM_SCANNER_UNIT_DEFINES_SVH
`define FREE_RUN_HISTOGRAM_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication
`define FRSU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRSU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/frsu_pkg.sv */
// ---------------------------------------------------------------------------
// Free run histogram scanner package
// Shared constants, codes and control structs.
// ---------------------------------------------------------------------------
`default_nettype none

package frsu_pkg;

    localparam int HIST_BINS_DEF   = 200;
    localparam int WORD_BITS_DEF   = 32;
    localparam int OFFSET_BITS_DEF = 16;
    localparam int MAX_RES         = 16;
    localparam int CNT_W           = 32;

    localparam logic [1:0] MODE_SCAN  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_BIN = 1'b1;

    // per-bit boundary flags from one lane
    typedef struct packed {
        logic open;
        logic close;
    } t_lane_flags;

    // merge stage status toward the controller
    typedef struct packed {
        logic active;   // a run is ready this cycle
        logic more;     // another run follows this one
    } t_step_ctl;

endpackage

`default_nettype wire

/* hw/rtl/frsu_lane.sv */
// ---------------------------------------------------------------------------
// Free run histogram scanner lane
// Classifies one bitmap bit as a run opening or a run closing boundary.
// ---------------------------------------------------------------------------
`default_nettype none

module frsu_lane (
    input  wire logic               i_en,
    input  wire logic               i_used,
    input  wire logic               i_prev_used,
    output frsu_pkg::t_lane_flags   o_flags
);

    always_comb begin
        o_flags.open  = i_en & ~i_used & i_prev_used;
        o_flags.close = i_en & i_used & ~i_prev_used;
    end

endmodule

`default_nettype wire

/* hw/rtl/frsu_merge.sv */
// ---------------------------------------------------------------------------
// Free run histogram scanner merge stage
// Walks the lane boundary flags of one word and yields one closed run
// per step, lowest bit first, then the run closed at the group end.
// ---------------------------------------------------------------------------
`default_nettype none

module frsu_merge #(
    parameter int WORD_BITS   = frsu_pkg::WORD_BITS_DEF,
    parameter int OFFSET_BITS = frsu_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [WORD_BITS-1:0]   i_open,
    input  wire logic [WORD_BITS-1:0]   i_close,
    input  wire logic [OFFSET_BITS-1:0] i_base,
    input  wire logic [OFFSET_BITS-1:0] i_start,
    input  wire logic                   i_end_pend,
    input  wire logic [OFFSET_BITS-1:0] i_end_pos,
    input  wire logic                   i_step,
    output frsu_pkg::t_step_ctl         o_ctl,
    output logic [OFFSET_BITS-1:0]      o_len,
    output logic [OFFSET_BITS-1:0]      o_start
);

    localparam int IX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0]   r_open;
    logic [WORD_BITS-1:0]   r_close;
    logic                   r_end;
    logic [OFFSET_BITS-1:0] r_base;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_end_pos;

    logic [IX_W-1:0]        s_lo_open;
    logic [IX_W-1:0]        s_lo_close;
    logic                   s_open_any;
    logic                   s_close_any;
    logic                   s_open_first;
    logic [WORD_BITS-1:0]   s_close_rest;
    logic [WORD_BITS-1:0]   s_close_low;
    logic [OFFSET_BITS-1:0] s_endpt;

    always_comb begin
        s_lo_open  = '0;
        s_lo_close = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (r_open[i]) begin
                s_lo_open = IX_W'(i);
            end
            if (r_close[i]) begin
                s_lo_close = IX_W'(i);
            end
        end
        s_open_any   = |r_open;
        s_close_any  = |r_close;
        // opens and closes alternate, so an open below the close starts this run
        s_open_first = s_open_any & (~s_close_any | (s_lo_open < s_lo_close));
        s_close_rest = r_close & (r_close - WORD_BITS'(1));
        s_close_low  = r_close ^ (r_close - WORD_BITS'(1));
        o_start      = s_open_first ? (r_base + OFFSET_BITS'(s_lo_open)) : r_start;
        s_endpt      = s_close_any ? (r_base + OFFSET_BITS'(s_lo_close)) : r_end_pos;
        o_len        = s_endpt - o_start;
        o_ctl.active = s_close_any | r_end;
        o_ctl.more   = s_close_any & ((|s_close_rest) | r_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= '0;
            r_close <= '0;
            r_end   <= 1'b0;
        end else if (i_load) begin
            r_open  <= i_open;
            r_close <= i_close;
            r_end   <= i_end_pend;
        end else if (i_step) begin
            if (s_close_any) begin
                r_close <= s_close_rest;
                r_open  <= r_open & ~s_close_low;
            end else begin
                r_end <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_base    <= i_base;
            r_start   <= i_start;
            r_end_pos <= i_end_pos;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/frsu_hist.sv */
// ---------------------------------------------------------------------------
// Free run histogram scanner histogram store
// Saturating bin counters in a memory with per-bin valid flags, a two
// stage read-modify-write and forwarding of the last written bin.
// ---------------------------------------------------------------------------
`default_nettype none
`include "free_run_histogram_scanner_unit_defines.svh"

module frsu_hist #(
    parameter  int HIST_BINS = frsu_pkg::HIST_BINS_DEF,
    localparam int HB_W      = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_inc,
    input  wire logic [HB_W-1:0]            i_inc_addr,
    input  wire logic                       i_rd,
    input  wire logic [HB_W-1:0]            i_rd_addr,
    input  wire logic                       i_clear,
    output logic [frsu_pkg::CNT_W-1:0]      o_count,
    output logic                            o_busy
);

    localparam int CW = frsu_pkg::CNT_W;

    logic [CW-1:0]        r_mem [HIST_BINS];
    logic [HIST_BINS-1:0] r_vld;
    logic [CW-1:0]        r_rdata;
    logic [HB_W-1:0]      r_raddr;
    logic                 r_s2_v;
    logic [HB_W-1:0]      r_s2_addr;
    logic                 r_lw_v;
    logic [HB_W-1:0]      r_lw_addr;
    logic [CW-1:0]        r_lw_data;

    logic [HB_W-1:0]      s_addr;
    logic                 s_ren;
    logic [CW-1:0]        s_cur;
    logic [CW-1:0]        s_wdata;

    always_comb begin
        s_addr = i_inc ? i_inc_addr : i_rd_addr;
        s_ren  = i_inc | i_rd;
        // the registered read missed the write that landed at the same edge
        if (r_lw_v && (r_lw_addr == r_s2_addr)) begin
            s_cur = r_lw_data;
        end else if (r_vld[r_s2_addr]) begin
            s_cur = r_rdata;
        end else begin
            s_cur = '0;
        end
        s_wdata = (&s_cur) ? s_cur : (s_cur + CW'(1));
        o_count = r_vld[r_raddr] ? r_rdata : '0;
        o_busy  = r_s2_v;
    end

    always_ff @(posedge i_clk) begin
        if (s_ren) begin
            r_rdata <= r_mem[s_addr];
            r_raddr <= s_addr;
        end
        if (r_s2_v) begin
            r_mem[r_s2_addr] <= s_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_addr <= i_inc_addr;
        r_lw_addr <= r_s2_addr;
        r_lw_data <= s_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_lw_v <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_s2_v <= i_inc;
            r_lw_v <= r_s2_v & ~i_clear;
            if (i_clear) begin
                r_vld <= '0;
            end else if (r_s2_v) begin
                r_vld[r_s2_addr] <= 1'b1;
            end
        end
    end

    `FRSU_ASSERT_NXT(a_inc_reaches_s2, i_clk, i_rst_n, i_inc, r_s2_v, "increment lost")
    `FRSU_ASSERT_IMP(a_s2_in_range, i_clk, i_rst_n, r_s2_v,
        32'(r_s2_addr) < 32'(HIST_BINS), "bin write out of range")
    `FRSU_ASSERT_IMP(a_clear_idle, i_clk, i_rst_n, i_clear, !r_s2_v && !i_inc,
        "clear during update")
    `FRSU_ASSERT_IMP(a_one_read, i_clk, i_rst_n, i_inc, !i_rd, "read port conflict")

endmodule

`default_nettype wire

/* hw/rtl/free_run_histogram_scanner_unit.sv */
// ---------------------------------------------------------------------------
// Free run histogram scanner
// Finds free bit runs in a group bitmap, keeps a run length histogram
// and the largest run record.
// ---------------------------------------------------------------------------
// A scan word is accepted while idle, then the merge stage delivers one
// closed run per cycle while the result side does not stall (including a
// run closed at the group end), followed by a drain while the last
// histogram update retires; the pace is set by the single read-modify-write
// port of the histogram memory and by stalls on the result side.
// Histogram bins reset and clear at once through per-bin valid flags. At most
// sixteen run reports leave per word; later runs still count.
`default_nettype none

module free_run_histogram_scanner_unit #(
    parameter int HIST_BINS   = frsu_pkg::HIST_BINS_DEF,
    parameter int WORD_BITS   = frsu_pkg::WORD_BITS_DEF,
    parameter int OFFSET_BITS = frsu_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_mode,
    input  wire logic [WORD_BITS-1:0]  i_bitmap_word,
    input  wire logic [5:0]            i_valid_bits,
    input  wire logic                  i_last_of_group,
    input  wire logic [63:0]           i_group_block,
    input  wire logic [15:0]           i_chain_index,
    input  wire logic [7:0]            i_bin_index,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_kind,
    output logic [15:0]                o_run_length,
    output logic [15:0]                o_run_start,
    output logic [63:0]                o_run_group,
    output logic [31:0]                o_bin_count,
    output logic [15:0]                o_largest_length,
    output logic [15:0]                o_largest_start,
    output logic [63:0]                o_largest_group,
    output logic [15:0]                o_largest_chain,
    output logic                       o_last
);

    localparam int OB    = OFFSET_BITS;
    localparam int IX_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int NB_W  = $clog2(WORD_BITS + 1);
    localparam int HB_W  = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam int NR_W  = $clog2(frsu_pkg::MAX_RES + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_RDOUT = 5'b01000,
        S_HOLD  = 5'b10000
    } t_state;

    t_state            r_state;
    logic [OB-1:0]     r_offset;
    logic              r_in_free;
    logic [OB-1:0]     r_open_start;
    logic [OB-1:0]     r_best_len;
    logic [OB-1:0]     r_best_start;
    logic [63:0]       r_best_grp;
    logic [15:0]       r_best_chain;
    logic [63:0]       r_grp;
    logic [15:0]       r_chain;
    logic [NR_W-1:0]   r_nres;
    logic              r_bin_oob;
    logic              r_ov;

    logic                   s_accept;
    logic [NB_W-1:0]        s_nb;
    logic [IX_W-1:0]        s_nbm1;
    logic                   s_final_free;
    logic [WORD_BITS-1:0]   s_open;
    logic [WORD_BITS-1:0]   s_close;
    logic [IX_W-1:0]        s_hi_open;
    logic [OB-1:0]          s_end_pos;
    logic [OB-1:0]          s_final_start;
    logic                   s_load;
    frsu_pkg::t_step_ctl    s_ctl;
    logic [OB-1:0]          s_len;
    logic [OB-1:0]          s_start;
    logic                   s_emit;
    logic                   s_out_free;
    logic                   s_ov_set;
    logic                   s_step;
    logic                   s_better;
    logic                   s_inc;
    logic                   s_rd;
    logic                   s_clear;
    logic [31:0]            s_count;
    logic                   s_busy;

    frsu_pkg::t_lane_flags  s_flags [WORD_BITS];

    always_comb begin
        if (7'(i_valid_bits) > 7'(WORD_BITS)) begin
            s_nb = NB_W'(WORD_BITS);
        end else begin
            s_nb = NB_W'(i_valid_bits);
        end
        s_nbm1 = IX_W'(s_nb - NB_W'(1));
    end

    for (genvar g = 0; g < WORD_BITS; g++) begin : g_lane
        logic s_prev;
        if (g == 0) begin : g_first
            assign s_prev = ~r_in_free;
        end else begin : g_rest
            assign s_prev = i_bitmap_word[g-1];
        end
        frsu_lane u_lane (
            .i_en        (NB_W'(g) < s_nb),
            .i_used      (i_bitmap_word[g]),
            .i_prev_used (s_prev),
            .o_flags     (s_flags[g])
        );
        assign s_open[g]  = s_flags[g].open;
        assign s_close[g] = s_flags[g].close;
    end

    always_comb begin
        s_hi_open = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (s_open[i]) begin
                s_hi_open = IX_W'(i);
            end
        end
        s_final_free  = (s_nb == '0) ? r_in_free : ~i_bitmap_word[s_nbm1];
        s_end_pos     = r_offset + OB'(s_nb);
        s_final_start = (|s_open) ? (r_offset + OB'(s_hi_open)) : r_open_start;
    end

    always_comb begin
        o_stall    = (r_state != S_IDLE);
        s_accept   = i_valid & ~o_stall;
        s_load     = s_accept & (i_mode == frsu_pkg::MODE_SCAN);
        s_rd       = s_accept & (i_mode == frsu_pkg::MODE_READ);
        s_clear    = s_accept & (i_mode == frsu_pkg::MODE_CLEAR);
        s_out_free = ~r_ov | ~i_stall;
        s_emit     = (r_nres < NR_W'(frsu_pkg::MAX_RES));
        s_step     = (r_state == S_SCAN) & s_ctl.active & (~s_emit | s_out_free);
        s_better   = s_len > r_best_len;
        s_inc      = s_step & (64'(s_len) < 64'(HIST_BINS));
        s_ov_set   = (s_step & s_emit) |
                     (((r_state == S_RDOUT) | (r_state == S_HOLD)) & s_out_free);
    end

    frsu_merge #(
        .WORD_BITS   (WORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s_load),
        .i_open     (s_open),
        .i_close    (s_close),
        .i_base     (r_offset),
        .i_start    (r_open_start),
        .i_end_pend (i_last_of_group & s_final_free),
        .i_end_pos  (s_end_pos),
        .i_step     (s_step),
        .o_ctl      (s_ctl),
        .o_len      (s_len),
        .o_start    (s_start)
    );

    frsu_hist #(
        .HIST_BINS (HIST_BINS)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_inc      (s_inc),
        .i_inc_addr (HB_W'(s_len)),
        .i_rd       (s_rd),
        .i_rd_addr  (HB_W'(i_bin_index)),
        .i_clear    (s_clear),
        .o_count    (s_count),
        .o_busy     (s_busy)
    );

    // control and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_offset     <= '0;
            r_in_free    <= 1'b0;
            r_open_start <= '0;
            r_best_len   <= '0;
            r_best_start <= '0;
            r_best_grp   <= '0;
            r_best_chain <= '0;
            r_nres       <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (s_ov_set) begin
                r_ov <= 1'b1;
            end else if (s_out_free) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_load) begin
                        r_state      <= S_SCAN;
                        r_nres       <= '0;
                        r_offset     <= i_last_of_group ? '0 : s_end_pos;
                        r_in_free    <= i_last_of_group ? 1'b0 : s_final_free;
                        r_open_start <= s_final_start;
                    end else if (s_rd) begin
                        r_state <= S_RDOUT;
                    end else if (s_clear) begin
                        r_best_len   <= '0;
                        r_best_start <= '0;
                        r_best_grp   <= '0;
                        r_best_chain <= '0;
                    end
                end
                S_SCAN: begin
                    if (!s_ctl.active) begin
                        r_state <= S_DRAIN;
                    end
                    if (s_step) begin
                        if (s_better) begin
                            r_best_len   <= s_len;
                            r_best_start <= s_start;
                            r_best_grp   <= r_grp;
                            r_best_chain <= r_chain;
                        end
                        if (s_emit) begin
                            r_nres <= r_nres + NR_W'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    if (!s_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RDOUT: begin
                    if (s_out_free) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // count stays in the histogram read register
                    if (s_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // item fields and result beat payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_grp     <= i_group_block;
            r_chain   <= i_chain_index;
            r_bin_oob <= (32'(i_bin_index) >= 32'(HIST_BINS));
        end
        if (s_step && s_emit) begin
            o_kind           <= frsu_pkg::KIND_RUN;
            o_run_length     <= 16'(64'(s_len));
            o_run_start      <= 16'(64'(s_start));
            o_run_group      <= r_grp;
            o_bin_count      <= '0;
            o_largest_length <= s_better ? 16'(64'(s_len)) : 16'(64'(r_best_len));
            o_largest_start  <= s_better ? 16'(64'(s_start)) : 16'(64'(r_best_start));
            o_largest_group  <= s_better ? r_grp : r_best_grp;
            o_largest_chain  <= s_better ? r_chain : r_best_chain;
            o_last           <= ~s_ctl.more | (r_nres == NR_W'(frsu_pkg::MAX_RES - 1));
        end else if ((r_state == S_RDOUT || r_state == S_HOLD) && s_out_free) begin
            o_kind           <= frsu_pkg::KIND_BIN;
            o_run_length     <= '0;
            o_run_start      <= '0;
            o_run_group      <= '0;
            o_bin_count      <= r_bin_oob ? '0 : s_count;
            o_largest_length <= 16'(64'(r_best_len));
            o_largest_start  <= 16'(64'(r_best_start));
            o_largest_group  <= r_best_grp;
            o_largest_chain  <= r_best_chain;
            o_last           <= 1'b1;
        end
    end

    assign o_valid = r_ov;

endmodule

`default_nettype wire
